// File: rtl/ccrp_pkg.sv
// ============================================================================
// ccrp_pkg
// Shared types, register numbers and decode helpers for the chipset
// configuration register port.
// ============================================================================
package ccrp_pkg;

    localparam int REG_COUNT_DEF = 128;

    localparam logic [7:0] BASE_ALT   = 8'h60;
    localparam logic [7:0] LAST_40X   = 8'h11;
    localparam logic [7:0] LAST_471   = 8'h76;

    localparam logic [15:0] PORT_INDEX = 16'h0022;
    localparam logic [15:0] PORT_DATA  = 16'h0023;
    localparam logic [15:0] PORT_SCR0  = 16'h00E1;
    localparam logic [15:0] PORT_SCR1  = 16'h00E2;

    localparam logic [7:0] R_SIZE     = 8'h00;
    localparam logic [7:0] R_CACHE    = 8'h01;
    localparam logic [7:0] R_SHADOW   = 8'h02;
    localparam logic [7:0] R_ROMCS    = 8'h03;
    localparam logic [7:0] R_CLK      = 8'h08;
    localparam logic [7:0] R_MEMSZ    = 8'h09;
    localparam logic [7:0] R_MISC     = 8'h0B;
    localparam logic [7:0] R_CTL11    = 8'h11;
    localparam logic [7:0] R_CTL12    = 8'h12;
    localparam logic [7:0] R_SMRAM    = 8'h13;
    localparam logic [7:0] R_SMI_LO   = 8'h14;
    localparam logic [7:0] R_SMI_HI   = 8'h15;
    localparam logic [7:0] R_SMI_CTL  = 8'h18;
    localparam logic [7:0] R_SMI_STS  = 8'h19;
    localparam logic [7:0] R_SRST     = 8'h1C;
    localparam logic [7:0] R_CTL1F    = 8'h1F;
    localparam logic [7:0] R_PORT92   = 8'h22;
    localparam logic [7:0] R_CTL23    = 8'h23;
    localparam logic [7:0] R_CTL26    = 8'h26;

    localparam logic [7:0] IDX_EXTRA  = 8'h00;
    localparam logic [7:0] IDX_FWD    = 8'h1C;
    localparam logic [7:0] IDX_MASKED = 8'h62;

    typedef enum logic [2:0] {
        CFG_VARIANT = 3'd0,
        CFG_BASE    = 3'd1,
        CFG_SLOW    = 3'd2,
        CFG_LARGE   = 3'd3,
        CFG_RAMSZ   = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_SMI   = 2'd1,
        EV_IRQ12 = 2'd2,
        EV_IRQ15 = 2'd3
    } smi_event_t;

    typedef enum logic [2:0] {
        WIN_OFF = 3'd0,
        WIN_E_A = 3'd1,
        WIN_E_B = 3'd2,
        WIN_E_E = 3'd3,
        WIN_6_A = 3'd4,
        WIN_6_B = 3'd5
    } smram_win_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic       v471;
        logic [7:0] base;
        logic       slow;
        logic       big_mem;
        logic [7:0] ramsz;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{v471: 1'b0, base: 8'd80, slow: 1'b0,
                                   big_mem: 1'b0, ramsz: 8'd0};

    typedef struct packed {
        logic capture;
        logic execute;
    } dp_cmd_t;

    function automatic logic [7:0] reg_default(input logic [7:0] rel, input cfg_t c);
        logic [7:0] v;
        v = 8'h00;
        if (rel == R_CLK && c.slow)
        begin
            v = 8'h80;
        end
        if (c.v471)
        begin
            unique case (rel)
                R_MEMSZ: v = 8'h40 | c.ramsz;
                R_CTL11: v = 8'h09;
                R_CTL12: v = 8'hFF;
                R_CTL1F: v = 8'h20;
                R_CTL23: v = 8'hF0;
                R_CTL26: v = 8'h01;
                default: v = v;
            endcase
        end
        else
        begin
            unique case (rel)
                R_SIZE:  v = c.ramsz;
                R_CTL11: v = 8'h01;
                default: v = v;
            endcase
        end
        return v;
    endfunction

    function automatic smram_win_t smram_decode(input logic [7:0] val);
        smram_win_t w;
        unique case (val[6:5])
            2'd0:    w = val[7] ? WIN_6_A : WIN_E_A;
            2'd1:    w = val[7] ? WIN_6_B : WIN_E_B;
            2'd2:    w = val[7] ? WIN_OFF : WIN_E_E;
            default: w = WIN_OFF;
        endcase
        return w;
    endfunction

endpackage

// File: rtl/ccrp_ctrl.sv
// ============================================================================
// ccrp_ctrl
// Transaction sequencer: capture and register file read, execute, then hold
// the result until the output side takes it.
// ============================================================================
module ccrp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              out_stall,
    output logic              in_stall,
    output logic              out_valid,
    output ccrp_pkg::dp_cmd_t cmd
);
    import ccrp_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        in_stall    = 1'b1;
        out_valid   = 1'b0;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.execute = 1'b1;
                state_next  = ST_DONE;
            end
            ST_DONE:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/ccrp_dp.sv
// ============================================================================
// ccrp_dp
// Register file, index and side state, access decode and memory-map decode
// of the configuration register port.
// ============================================================================
module ccrp_dp #(
    parameter int REG_COUNT = ccrp_pkg::REG_COUNT_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ccrp_pkg::dp_cmd_t cmd,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [7:0]        cfg_data,
    input  logic              func,
    input  logic [15:0]       io_port,
    input  logic [7:0]        write_data,
    output logic [7:0]        read_data,
    output logic [7:0]        shadow_read_mask,
    output logic [7:0]        shadow_write_mask,
    output logic [7:0]        rom_ext_mask,
    output logic              ext_cache_on,
    output logic [2:0]        smram_window,
    output logic              smram_flag,
    output logic              top_remap_on,
    output logic [1:0]        smi_event,
    output logic              port92_on,
    output logic              cmos_forward,
    output logic              soft_reset_block
);
    import ccrp_pkg::*;

    localparam int AW = $clog2(REG_COUNT);
    localparam bit HAS_STS = (int'(R_SMI_STS) < REG_COUNT);

    // configuration
    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       cfg_hit;

    // architectural state
    logic [7:0] index_reg;
    logic [7:0] index_next;
    logic [7:0] extra_reg;
    logic [7:0] extra_next;
    logic [7:0] scr0_reg;
    logic [7:0] scr0_next;
    logic [7:0] scr1_reg;
    logic [7:0] scr1_next;
    logic       cache_reg;
    logic       cache_next;
    smram_win_t smram_reg;
    smram_win_t smram_next;
    logic       attr_reg;
    logic       attr_next;
    logic       srm_reg;
    logic       srm_next;
    logic       p92_reg;
    logic       p92_next;

    // register copies that feed decode every transaction
    logic [7:0] r02_reg;
    logic [7:0] r02_next;
    logic [7:0] r03_reg;
    logic [7:0] r03_next;
    logic [7:0] r08_reg;
    logic [7:0] r08_next;
    logic [7:0] r0b_reg;
    logic [7:0] r0b_next;
    logic [7:0] r14_reg;
    logic [7:0] r14_next;
    logic [7:0] r15_reg;
    logic [7:0] r15_next;
    logic [7:0] r18_reg;
    logic [7:0] r18_next;
    logic [7:0] r19_reg;
    logic [7:0] r19_next;

    // register file
    logic [7:0]           mem [REG_COUNT];
    logic [REG_COUNT-1:0] valid_reg;
    logic [7:0]           mem_rd_reg;
    logic                 vld_rd_reg;

    // captured transaction
    logic          func_reg;
    logic [15:0]   port_reg;
    logic [7:0]    wdata_reg;
    logic          dec_reg;
    logic [AW-1:0] rel_reg;

    // decode
    logic [7:0] last;
    logic [7:0] diff;
    logic       dec;
    logic [7:0] rel8;
    logic [7:0] mem_old;
    logic [7:0] reg_val;
    logic [7:0] data_rd_val;
    logic       fwd;
    logic       base_alt;
    logic       smi_hit;
    smi_event_t ev;
    logic [7:0] r19_set;
    logic       dw;
    logic       dw_dec;
    logic [7:0] wr_val;
    logic       rd;
    logic [7:0] rdata;
    logic [7:0] sel;
    logic [7:0] rdm;
    logic [7:0] wrm;
    logic [7:0] romcs;
    logic       remap;

    always_comb
    begin
        cfg_next = cfg_reg;
        cfg_hit  = 1'b0;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_VARIANT:
                begin
                    cfg_next.v471 = cfg_data[0];
                    cfg_hit       = 1'b1;
                end
                CFG_BASE:
                begin
                    cfg_next.base = cfg_data;
                    cfg_hit       = 1'b1;
                end
                CFG_SLOW:
                begin
                    cfg_next.slow = cfg_data[0];
                    cfg_hit       = 1'b1;
                end
                CFG_LARGE:
                begin
                    cfg_next.big_mem = cfg_data[0];
                    cfg_hit          = 1'b1;
                end
                CFG_RAMSZ:
                begin
                    cfg_next.ramsz = cfg_data;
                    cfg_hit        = 1'b1;
                end
                default:
                begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
    end

    // index decode against the current index
    always_comb
    begin
        base_alt = (cfg_reg.base == BASE_ALT);
        last     = cfg_reg.v471 ? LAST_471 : LAST_40X;
        diff     = index_reg - cfg_reg.base;
        dec      = (index_reg >= cfg_reg.base) && (diff <= last)
                   && ({1'b0, diff} < 9'(REG_COUNT));
    end

    // transaction execute
    always_comb
    begin
        rel8    = 8'(rel_reg);
        rd      = func_reg;
        mem_old = vld_rd_reg ? mem_rd_reg : reg_default(rel8, cfg_reg);

        unique case (rel8)
            R_SHADOW:  reg_val = r02_reg;
            R_ROMCS:   reg_val = r03_reg;
            R_CLK:     reg_val = r08_reg;
            R_MISC:    reg_val = r0b_reg;
            R_SMI_LO:  reg_val = r14_reg;
            R_SMI_HI:  reg_val = r15_reg;
            R_SMI_CTL: reg_val = r18_reg;
            R_SMI_STS: reg_val = r19_reg;
            default:   reg_val = mem_old;
        endcase

        priority if (base_alt && index_reg == IDX_MASKED && dec_reg)
        begin
            data_rd_val = reg_val & 8'h3F;
        end
        else if (dec_reg)
        begin
            data_rd_val = reg_val;
        end
        else if (base_alt && index_reg == IDX_EXTRA)
        begin
            data_rd_val = extra_reg;
        end
        else
        begin
            data_rd_val = 8'hFF;
        end

        fwd = rd && (port_reg == PORT_DATA) && cfg_reg.v471 && (index_reg == IDX_FWD)
              && !dec_reg && !(base_alt && index_reg == IDX_EXTRA);

        // software SMI, decoded with the registers before this transaction
        smi_hit = !rd && cfg_reg.v471 && r0b_reg[7] && r18_reg[1]
                  && (port_reg == {r15_reg, r14_reg});
        priority if (!smi_hit)
        begin
            ev = EV_NONE;
        end
        else if (r0b_reg[4])
        begin
            ev = EV_SMI;
        end
        else if (r0b_reg[3])
        begin
            ev = EV_IRQ15;
        end
        else
        begin
            ev = EV_IRQ12;
        end
        r19_set = (smi_hit && HAS_STS) ? (r19_reg | 8'h02) : r19_reg;

        dw     = !rd && (port_reg == PORT_DATA);
        dw_dec = dw && dec_reg;
        wr_val = (rel8 == R_SMI_STS) ? (r19_set & ~wdata_reg) : wdata_reg;

        r02_next = (dw_dec && rel8 == R_SHADOW)  ? wdata_reg : r02_reg;
        r03_next = (dw_dec && rel8 == R_ROMCS)   ? wdata_reg : r03_reg;
        r08_next = (dw_dec && rel8 == R_CLK)     ? wdata_reg : r08_reg;
        r0b_next = (dw_dec && rel8 == R_MISC)    ? wdata_reg : r0b_reg;
        r14_next = (dw_dec && rel8 == R_SMI_LO)  ? wdata_reg : r14_reg;
        r15_next = (dw_dec && rel8 == R_SMI_HI)  ? wdata_reg : r15_reg;
        r18_next = (dw_dec && rel8 == R_SMI_CTL) ? wdata_reg : r18_reg;
        r19_next = (dw_dec && rel8 == R_SMI_STS) ? wr_val    : r19_set;

        cache_next = cache_reg;
        if (dw_dec && rel8 == R_CACHE)
        begin
            cache_next = ((wdata_reg & 8'h84) == 8'h84);
        end

        smram_next = smram_reg;
        attr_next  = attr_reg;
        if (dw_dec && rel8 == R_SMRAM && cfg_reg.v471
            && (((wdata_reg ^ mem_old) & 8'hF0) != 8'h00))
        begin
            smram_next = smram_decode(wdata_reg);
            attr_next  = (smram_decode(wdata_reg) != WIN_OFF) && wdata_reg[4];
        end

        srm_next = smi_hit ? 1'b1 : srm_reg;
        if (dw_dec && rel8 == R_SRST && cfg_reg.v471)
        begin
            srm_next = 1'b0;
        end

        p92_next = p92_reg;
        if (dw_dec && rel8 == R_PORT92 && cfg_reg.v471 && (wdata_reg[0] ^ mem_old[0]))
        begin
            p92_next = wdata_reg[0];
        end

        extra_next = extra_reg;
        if (dw && !dec_reg && base_alt && index_reg == IDX_EXTRA)
        begin
            extra_next = wdata_reg;
        end

        index_next = index_reg;
        if (port_reg == PORT_INDEX && !rd)
        begin
            index_next = wdata_reg;
        end
        else if (port_reg == PORT_DATA)
        begin
            index_next = (rd && base_alt) ? index_reg : 8'h00;
        end

        scr0_next = (!rd && port_reg == PORT_SCR0) ? wdata_reg : scr0_reg;
        scr1_next = (!rd && port_reg == PORT_SCR1) ? wdata_reg : scr1_reg;

        priority if (!rd)
        begin
            rdata = 8'h00;
        end
        else if (port_reg == PORT_DATA)
        begin
            rdata = data_rd_val;
        end
        else if (port_reg == PORT_SCR0)
        begin
            rdata = scr0_reg;
        end
        else if (port_reg == PORT_SCR1)
        begin
            rdata = scr1_reg;
        end
        else
        begin
            rdata = 8'hFF;
        end

        // memory map from the register contents after this transaction
        sel   = {2'b11, r02_next[5:0]};
        rdm   = r02_next[7] ? sel : 8'h00;
        wrm   = r02_next[6] ? 8'h00 : sel;
        romcs = 8'hC0;
        if (r03_next[6])
        begin
            romcs = romcs | 8'h01;
        end
        if (r03_next[7])
        begin
            romcs = romcs | 8'h30;
        end
        if (r08_next[2])
        begin
            romcs = romcs | 8'h02;
        end
        remap = cfg_reg.v471 && !cfg_reg.big_mem && (((rdm | wrm) & 8'h3C) == 8'h00)
                && !r0b_next[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg   <= CFG_RESET;
            index_reg <= 8'h00;
            valid_reg <= '0;
            extra_reg <= (CFG_RESET.base == BASE_ALT) ? 8'h24 : 8'h00;
            scr0_reg  <= 8'hFF;
            scr1_reg  <= 8'hFF;
            cache_reg <= 1'b0;
            smram_reg <= CFG_RESET.v471 ? WIN_E_A : WIN_OFF;
            attr_reg  <= 1'b0;
            srm_reg   <= 1'b0;
            p92_reg   <= 1'b0;
            r02_reg   <= 8'h00;
            r03_reg   <= 8'h00;
            r08_reg   <= CFG_RESET.slow ? 8'h80 : 8'h00;
            r0b_reg   <= 8'h00;
            r14_reg   <= 8'h00;
            r15_reg   <= 8'h00;
            r18_reg   <= 8'h00;
            r19_reg   <= 8'h00;
        end
        else if (cfg_hit)
        begin
            // strap change: register, index and side state back to its initial values
            cfg_reg   <= cfg_next;
            index_reg <= 8'h00;
            valid_reg <= '0;
            extra_reg <= (cfg_next.base == BASE_ALT) ? 8'h24 : 8'h00;
            scr0_reg  <= 8'hFF;
            scr1_reg  <= 8'hFF;
            cache_reg <= 1'b0;
            smram_reg <= cfg_next.v471 ? WIN_E_A : WIN_OFF;
            attr_reg  <= 1'b0;
            srm_reg   <= 1'b0;
            p92_reg   <= 1'b0;
            r02_reg   <= 8'h00;
            r03_reg   <= 8'h00;
            r08_reg   <= cfg_next.slow ? 8'h80 : 8'h00;
            r0b_reg   <= 8'h00;
            r14_reg   <= 8'h00;
            r15_reg   <= 8'h00;
            r18_reg   <= 8'h00;
            r19_reg   <= 8'h00;
        end
        else if (cmd.execute)
        begin
            index_reg <= index_next;
            extra_reg <= extra_next;
            scr0_reg  <= scr0_next;
            scr1_reg  <= scr1_next;
            cache_reg <= cache_next;
            smram_reg <= smram_next;
            attr_reg  <= attr_next;
            srm_reg   <= srm_next;
            p92_reg   <= p92_next;
            r02_reg   <= r02_next;
            r03_reg   <= r03_next;
            r08_reg   <= r08_next;
            r0b_reg   <= r0b_next;
            r14_reg   <= r14_next;
            r15_reg   <= r15_next;
            r18_reg   <= r18_next;
            r19_reg   <= r19_next;
            if (dw_dec)
            begin
                valid_reg[rel_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.execute && dw_dec)
        begin
            mem[rel_reg] <= wr_val;
        end
        if (cmd.capture)
        begin
            mem_rd_reg <= mem[diff[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg   <= func;
            port_reg   <= io_port;
            wdata_reg  <= write_data;
            dec_reg    <= dec;
            rel_reg    <= diff[AW-1:0];
            vld_rd_reg <= valid_reg[diff[AW-1:0]];
        end
        if (cmd.execute)
        begin
            read_data         <= rdata;
            shadow_read_mask  <= rdm;
            shadow_write_mask <= wrm;
            rom_ext_mask      <= romcs;
            ext_cache_on      <= cache_next;
            smram_window      <= smram_next;
            smram_flag        <= attr_next;
            top_remap_on      <= remap;
            smi_event         <= ev;
            port92_on         <= p92_next;
            cmos_forward      <= fwd;
            soft_reset_block  <= srm_next;
        end
    end

endmodule

// File: rtl/chipset_config_register_port_unit.sv
// ============================================================================
// chipset_config_register_port_unit
// Index/data configuration register port with memory-map and SMI decode.
// ============================================================================
// Each I/O transaction is captured together with a read of the register
// file (a synchronous-read memory), then executed to update state, and its
// result is then held until the output side takes it; the next transaction
// is accepted in the cycle after that, so no new transaction is taken while
// a result is pending. The register file needs no clearing pass: per-entry
// valid bits make untouched registers read their strap defaults. A
// configuration write returns the register, index and side state to its
// strap defaults at once.
module chipset_config_register_port_unit #(
    parameter int REG_COUNT = ccrp_pkg::REG_COUNT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic [15:0] io_port,
    input  logic [7:0]  write_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  read_data,
    output logic [7:0]  shadow_read_mask,
    output logic [7:0]  shadow_write_mask,
    output logic [7:0]  rom_ext_mask,
    output logic        ext_cache_on,
    output logic [2:0]  smram_window,
    output logic        smram_flag,
    output logic        top_remap_on,
    output logic [1:0]  smi_event,
    output logic        port92_on,
    output logic        cmos_forward,
    output logic        soft_reset_block,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import ccrp_pkg::*;

    dp_cmd_t cmd;

    assign cfg_ready = 1'b1;

    ccrp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_stall (out_stall),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    ccrp_dp #(
        .REG_COUNT (REG_COUNT)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .cfg_we            (cfg_valid && cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .func              (func),
        .io_port           (io_port),
        .write_data        (write_data),
        .read_data         (read_data),
        .shadow_read_mask  (shadow_read_mask),
        .shadow_write_mask (shadow_write_mask),
        .rom_ext_mask      (rom_ext_mask),
        .ext_cache_on      (ext_cache_on),
        .smram_window      (smram_window),
        .smram_flag        (smram_flag),
        .top_remap_on      (top_remap_on),
        .smi_event         (smi_event),
        .port92_on         (port92_on),
        .cmos_forward      (cmos_forward),
        .soft_reset_block  (soft_reset_block)
    );

    // no new transaction while a result is pending
    a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("transaction accepted while result pending");

    // result is presented after acceptance and the execute state
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> ##1 out_valid)
        else $error("result missing after transaction");

    a_smram_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && smram_flag) |-> (smram_window != 3'(WIN_OFF)))
        else $error("smram attribute set with window off");

    a_smram_win: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (smram_window <= 3'(WIN_6_B)))
        else $error("smram window code out of range");

endmodule
